@@ rtl/ozrc_pkg.sv @@
// ----------------------------------------------------------------------------
// ozrc_pkg
// shared constants and types for the occupancy zone relay controller
// ----------------------------------------------------------------------------
package ozrc_pkg;

	localparam int ZONE_COUNT  = 8;
	localparam int RELAY_COUNT = 8;
	localparam int COORD_BITS  = 12;
	localparam int ZIDX_BITS   = 3;
	localparam int MS_PER_S    = 1000;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_DETECT = 2'd1;
	localparam logic [1:0] OP_FRAME  = 2'd2;
	localparam logic [1:0] OP_ESTOP  = 2'd3;

	localparam logic [1:0] REG_FRAME_W = 2'd0;
	localparam logic [1:0] REG_FRAME_H = 2'd1;
	localparam logic [1:0] REG_POLARITY = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCALE = 5'b00010,
		ST_WALK  = 5'b00100,
		ST_DROP  = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	// one zone table entry
	typedef struct packed {
		logic [COORD_BITS-1:0] left;
		logic [COORD_BITS-1:0] top;
		logic [COORD_BITS-1:0] wide;
		logic [COORD_BITS-1:0] tall;
		logic [11:0]           timeout;
		logic [RELAY_COUNT-1:0] relays;
	} zone_t;

	function automatic logic [COORD_BITS-1:0] sat_coord(input logic [15:0] v);
		if (v > 16'((1 << COORD_BITS) - 1))
			return COORD_BITS'((1 << COORD_BITS) - 1);
		return v[COORD_BITS-1:0];
	endfunction

endpackage

@@ rtl/ozrc_scaler.sv @@
// ----------------------------------------------------------------------------
// ozrc_scaler
// shared multiplier: one q0.16 fraction times frame size per cycle
// ----------------------------------------------------------------------------
module ozrc_scaler (
	input  logic        clk,
	input  logic [15:0] frac,
	input  logic [11:0] size,
	output logic [11:0] scaled_q
);
	logic [27:0] prod;

	assign prod = 28'(frac) * 28'(size);

	always_ff @(posedge clk) begin
		scaled_q <= prod[27:16];
	end
endmodule

@@ rtl/occupancy_zone_relay_controller.sv @@
// load and detection give no result; frame end and emergency stop give one
// throughput: one item at a time; detection scaling reuses one 16x12 multiplier
// for four products, the detection walk takes one zone a cycle, and the frame end
// walk takes one zone a cycle but pauses for a drop step on each zone that expires
// reset clears the zone flags and relays and sets the config registers to 640, 480, high
module occupancy_zone_relay_controller (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// zone_index, x, y, w, h, timeout_s, relay_mask, zone_enable, now_ms
	input  logic [119:0] s_axis_tdata,
	// opcode
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// relay_on_mask, pin_levels, zone_active_mask, zone_hit_mask
	output logic [31:0]  m_axis_tdata
);
	localparam int ZN = ozrc_pkg::ZONE_COUNT;
	localparam int RN = ozrc_pkg::RELAY_COUNT;
	localparam int CB = ozrc_pkg::COORD_BITS;
	localparam int IB = ozrc_pkg::ZIDX_BITS;

	logic [11:0] frame_w_q, frame_h_q;
	logic        pol_q;

	ozrc_pkg::state_t state_q;
	ozrc_pkg::zone_t  zone_q [ZN];
	logic [31:0]      seen_q [ZN];
	logic [ZN-1:0]    valid_q, active_q, hits_q, rep_hits_q;
	logic [RN-1:0]    relay_q;
	logic [IB:0]      idx_q;
	logic [1:0]       op_q;
	logic [31:0]      now_q;
	logic [15:0]      box_q [4];
	logic [CB-1:0]    dbox_q [4];
	logic [RN-1:0]    kept_q;

	// input fields
	logic [1:0]  in_op;
	logic [2:0]  in_zi;
	logic [15:0] in_x, in_y, in_w, in_h;
	logic [11:0] in_to;
	logic [7:0]  in_rm;
	logic        in_en;
	logic [31:0] in_now;
	assign in_op  = s_axis_tuser;
	assign in_zi  = s_axis_tdata[2:0];
	assign in_x   = s_axis_tdata[18:3];
	assign in_y   = s_axis_tdata[34:19];
	assign in_w   = s_axis_tdata[50:35];
	assign in_h   = s_axis_tdata[66:51];
	assign in_to  = s_axis_tdata[78:67];
	assign in_rm  = s_axis_tdata[86:79];
	assign in_en  = s_axis_tdata[87];
	assign in_now = s_axis_tdata[119:88];

	logic in_fire, out_fire, cfg_wr;
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (state_q == ozrc_pkg::ST_IDLE);
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[3:2])
			ozrc_pkg::REG_FRAME_W:  prdata = {20'd0, frame_w_q};
			ozrc_pkg::REG_FRAME_H:  prdata = {20'd0, frame_h_q};
			ozrc_pkg::REG_POLARITY: prdata = {31'd0, pol_q};
			default:                prdata = 32'd0;
		endcase
	end

	// shared multiplier, step index selects operand
	logic [1:0]  sc_sel;
	logic [11:0] sc_out;
	assign sc_sel = idx_q[1:0];
	ozrc_scaler u_scaler (
		.clk      (clk),
		.frac     (box_q[sc_sel]),
		.size     (sc_sel[0] ? frame_h_q : frame_w_q),
		.scaled_q (sc_out)
	);

	// current zone of the walk
	logic [IB-1:0]  zi;
	ozrc_pkg::zone_t cz;
	logic [CB:0]    dx_w, dy_h, zl_w, zt_h;
	logic           overlap;
	logic [31:0]    elapsed, limit;
	logic           expire;
	assign zi = idx_q[IB-1:0];
	assign cz = zone_q[zi];
	assign dx_w = {1'b0, dbox_q[0]} + {1'b0, dbox_q[2]};
	assign dy_h = {1'b0, dbox_q[1]} + {1'b0, dbox_q[3]};
	assign zl_w = {1'b0, cz.left} + {1'b0, cz.wide};
	assign zt_h = {1'b0, cz.top} + {1'b0, cz.tall};
	assign overlap = ({1'b0, dbox_q[0]} < zl_w) && (dx_w > {1'b0, cz.left})
		&& ({1'b0, dbox_q[1]} < zt_h) && (dy_h > {1'b0, cz.top});
	assign elapsed = now_q - seen_q[zi];
	assign limit = 32'(cz.timeout) * 32'(ozrc_pkg::MS_PER_S);
	assign expire = valid_q[zi] && !hits_q[zi] && active_q[zi] && (elapsed >= limit);

	// relays still used by other active zones
	logic [RN-1:0] kept;
	always_comb begin
		kept = '0;
		for (int j = 0; j < ZN; j++)
			if (IB'(j) != zi && valid_q[j] && active_q[j])
				kept |= zone_q[j].relays;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q <= 12'd640;
			frame_h_q <= 12'd480;
			pol_q <= 1'b1;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				ozrc_pkg::REG_FRAME_W:  frame_w_q <= pwdata[11:0];
				ozrc_pkg::REG_FRAME_H:  frame_h_q <= pwdata[11:0];
				ozrc_pkg::REG_POLARITY: pol_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q <= in_op;
			now_q <= in_now;
			box_q[0] <= in_x;
			box_q[1] <= in_y;
			box_q[2] <= in_w;
			box_q[3] <= in_h;
		end
		if (in_fire && in_op == ozrc_pkg::OP_LOAD) begin
			zone_q[in_zi].left <= ozrc_pkg::sat_coord(in_x);
			zone_q[in_zi].top <= ozrc_pkg::sat_coord(in_y);
			zone_q[in_zi].wide <= ozrc_pkg::sat_coord(in_w);
			zone_q[in_zi].tall <= ozrc_pkg::sat_coord(in_h);
			zone_q[in_zi].timeout <= in_to;
			zone_q[in_zi].relays <= in_rm;
		end
		// scaled value arrives in the cycle after its step
		if (state_q == ozrc_pkg::ST_SCALE && idx_q != '0)
			dbox_q[2'(idx_q - 1'b1)] <= sc_out;
		if (state_q == ozrc_pkg::ST_WALK)
			kept_q <= kept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ozrc_pkg::ST_IDLE;
			valid_q <= '0;
			active_q <= '0;
			hits_q <= '0;
			rep_hits_q <= '0;
			relay_q <= '0;
			idx_q <= '0;
			m_axis_tvalid <= 1'b0;
			for (int k = 0; k < ZN; k++)
				seen_q[k] <= '0;
		end else begin
			unique case (state_q)
				ozrc_pkg::ST_IDLE: begin
					idx_q <= '0;
					if (in_fire) begin
						unique case (in_op)
							ozrc_pkg::OP_LOAD: begin
								valid_q[in_zi] <= in_en;
								active_q[in_zi] <= 1'b0;
								hits_q[in_zi] <= 1'b0;
							end
							ozrc_pkg::OP_DETECT: state_q <= ozrc_pkg::ST_SCALE;
							ozrc_pkg::OP_FRAME: state_q <= ozrc_pkg::ST_WALK;
							ozrc_pkg::OP_ESTOP: begin
								relay_q <= '0;
								active_q <= '0;
								hits_q <= '0;
								rep_hits_q <= '0;
								state_q <= ozrc_pkg::ST_OUT;
								m_axis_tvalid <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				ozrc_pkg::ST_SCALE: begin
					if (idx_q == (IB+1)'(4)) begin
						idx_q <= '0;
						state_q <= ozrc_pkg::ST_WALK;
					end else
						idx_q <= idx_q + 1'b1;
				end
				ozrc_pkg::ST_WALK: begin
					if (op_q == ozrc_pkg::OP_DETECT) begin
						if (valid_q[zi] && overlap)
							hits_q[zi] <= 1'b1;
					end else if (valid_q[zi] && hits_q[zi]) begin
						active_q[zi] <= 1'b1;
						seen_q[zi] <= now_q;
						relay_q <= relay_q | cz.relays;
					end
					if (op_q == ozrc_pkg::OP_FRAME && expire) begin
						active_q[zi] <= 1'b0;
						state_q <= ozrc_pkg::ST_DROP;
					end else if (idx_q == (IB+1)'(ZN - 1)) begin
						idx_q <= '0;
						if (op_q == ozrc_pkg::OP_FRAME) begin
							rep_hits_q <= hits_q;
							hits_q <= '0;
							state_q <= ozrc_pkg::ST_OUT;
							m_axis_tvalid <= 1'b1;
						end else
							state_q <= ozrc_pkg::ST_IDLE;
					end else
						idx_q <= idx_q + 1'b1;
				end
				ozrc_pkg::ST_DROP: begin
					relay_q <= relay_q & ~(cz.relays & ~kept_q);
					if (idx_q == (IB+1)'(ZN - 1)) begin
						idx_q <= '0;
						rep_hits_q <= hits_q;
						hits_q <= '0;
						state_q <= ozrc_pkg::ST_OUT;
						m_axis_tvalid <= 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ozrc_pkg::ST_WALK;
					end
				end
				ozrc_pkg::ST_OUT: begin
					if (out_fire) begin
						m_axis_tvalid <= 1'b0;
						state_q <= ozrc_pkg::ST_IDLE;
					end
				end
				default: state_q <= ozrc_pkg::ST_IDLE;
			endcase
		end
	end

	assign m_axis_tdata = {rep_hits_q, active_q, pol_q ? relay_q : ~relay_q, relay_q};

	ast_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid)
		else $error("ready while a result is pending");
	ast_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ozrc_pkg::ST_WALK) |-> idx_q < (IB+1)'(ZN))
		else $error("walk index out of range");
	ast_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
	ast_active_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ((active_q & ~valid_q) == '0))
		else $error("active zone without valid entry");
endmodule
